// ===== design/assert_macros.svh =====
// assertion macros shared by the lcd nibble sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LCDNIB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lcd nibble sequencer check failed");

// next-cycle implication, disabled while reset is asserted
`define LCDNIB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lcd nibble sequencer check failed");

`endif

// ===== design/lcdnib_pkg.sv =====
// types, codes and microcode rom of the lcd nibble write sequencer
`default_nettype none
package lcdnib_pkg;

	// request kinds
	localparam logic [2:0] REQ_CMD    = 3'd0;
	localparam logic [2:0] REQ_DATA   = 3'd1;
	localparam logic [2:0] REQ_INIT   = 3'd2;
	localparam logic [2:0] REQ_CLEAR  = 3'd3;
	localparam logic [2:0] REQ_CURSOR = 3'd4;

	// configuration register indexes
	localparam logic [2:0] CFG_POWER_ON = 3'd0;
	localparam logic [2:0] CFG_ENABLE   = 3'd1;
	localparam logic [2:0] CFG_GAP      = 3'd2;
	localparam logic [2:0] CFG_SETTLE   = 3'd3;
	localparam logic [2:0] CFG_CLEAR    = 3'd4;

	// configuration reset values
	localparam logic [15:0] RST_POWER_ON = 16'd20000;
	localparam logic [7:0]  RST_ENABLE   = 8'd1;
	localparam logic [15:0] RST_GAP      = 16'd200;
	localparam logic [15:0] RST_SETTLE   = 16'd2000;
	localparam logic [15:0] RST_CLEAR    = 16'd2000;

	localparam int COLUMNS_DEF = 16;

	// cursor base addresses
	localparam logic [7:0] DDRAM_ROW0 = 8'h80;
	localparam logic [7:0] DDRAM_ROW1 = 8'hC0;

	// microprogram
	localparam int UPC_W = 5;
	localparam logic [UPC_W-1:0] ENT_BYTE   = 5'd0;
	localparam logic [UPC_W-1:0] ENT_INIT   = 5'd2;
	localparam logic [UPC_W-1:0] ENT_CLEAR  = 5'd16;
	localparam logic [UPC_W-1:0] ENT_CURSOR = 5'd20;

	typedef enum logic [1:0] {
		OP_EMIT     = 2'b01,
		OP_EXIT_BAD = 2'b10
	} uop_t;

	typedef enum logic [2:0] {
		SET_GAP   = 3'b001,
		SET_BYTE  = 3'b010,
		SET_CLEAR = 3'b100
	} settle_sel_t;

	typedef struct packed {
		uop_t        op;
		logic        use_req;
		logic        hi;
		logic        wait_pow;
		settle_sel_t settle;
		logic        last;
		logic [7:0]  cbyte;
	} uword_t;

	// control from sequencer to datapath
	typedef struct packed {
		logic   act;
		uword_t w;
	} ctl_t;

	// configuration register file contents
	typedef struct packed {
		logic [15:0] power_on;
		logic [7:0]  enable;
		logic [15:0] gap;
		logic [15:0] settle;
		logic [15:0] clear;
	} cfg_t;

	function automatic uword_t uw(input uop_t op, input logic use_req, input logic hi,
		input logic wait_pow, input settle_sel_t settle, input logic last,
		input logic [7:0] cbyte);
		uword_t r;
		r.op       = op;
		r.use_req  = use_req;
		r.hi       = hi;
		r.wait_pow = wait_pow;
		r.settle   = settle;
		r.last     = last;
		r.cbyte    = cbyte;
		return r;
	endfunction

	// control store: one word per step
	function automatic uword_t ucode_rom(input logic [UPC_W-1:0] a);
		uword_t r;
		case (a)
			// command or data byte
			5'd0:  r = uw(OP_EMIT, 1'b1, 1'b1, 1'b0, SET_GAP,   1'b0, 8'h00);
			5'd1:  r = uw(OP_EMIT, 1'b1, 1'b0, 1'b0, SET_BYTE,  1'b1, 8'h00);
			// power-up init
			5'd2:  r = uw(OP_EMIT, 1'b0, 1'b1, 1'b1, SET_GAP,   1'b0, 8'h33);
			5'd3:  r = uw(OP_EMIT, 1'b0, 1'b0, 1'b0, SET_BYTE,  1'b0, 8'h33);
			5'd4:  r = uw(OP_EMIT, 1'b0, 1'b1, 1'b0, SET_GAP,   1'b0, 8'h32);
			5'd5:  r = uw(OP_EMIT, 1'b0, 1'b0, 1'b0, SET_BYTE,  1'b0, 8'h32);
			5'd6:  r = uw(OP_EMIT, 1'b0, 1'b1, 1'b0, SET_GAP,   1'b0, 8'h28);
			5'd7:  r = uw(OP_EMIT, 1'b0, 1'b0, 1'b0, SET_BYTE,  1'b0, 8'h28);
			5'd8:  r = uw(OP_EMIT, 1'b0, 1'b1, 1'b0, SET_GAP,   1'b0, 8'h0C);
			5'd9:  r = uw(OP_EMIT, 1'b0, 1'b0, 1'b0, SET_BYTE,  1'b0, 8'h0C);
			5'd10: r = uw(OP_EMIT, 1'b0, 1'b1, 1'b0, SET_GAP,   1'b0, 8'h06);
			5'd11: r = uw(OP_EMIT, 1'b0, 1'b0, 1'b0, SET_BYTE,  1'b0, 8'h06);
			5'd12: r = uw(OP_EMIT, 1'b0, 1'b1, 1'b0, SET_GAP,   1'b0, 8'h01);
			5'd13: r = uw(OP_EMIT, 1'b0, 1'b0, 1'b0, SET_CLEAR, 1'b0, 8'h01);
			5'd14: r = uw(OP_EMIT, 1'b0, 1'b1, 1'b0, SET_GAP,   1'b0, 8'h80);
			5'd15: r = uw(OP_EMIT, 1'b0, 1'b0, 1'b0, SET_BYTE,  1'b1, 8'h80);
			// clear and home
			5'd16: r = uw(OP_EMIT, 1'b0, 1'b1, 1'b0, SET_GAP,   1'b0, 8'h01);
			5'd17: r = uw(OP_EMIT, 1'b0, 1'b0, 1'b0, SET_CLEAR, 1'b0, 8'h01);
			5'd18: r = uw(OP_EMIT, 1'b0, 1'b1, 1'b0, SET_GAP,   1'b0, 8'h80);
			5'd19: r = uw(OP_EMIT, 1'b0, 1'b0, 1'b0, SET_BYTE,  1'b1, 8'h80);
			// set cursor: leave early on a bad position
			5'd20: r = uw(OP_EXIT_BAD, 1'b0, 1'b0, 1'b0, SET_GAP, 1'b0, 8'h00);
			5'd21: r = uw(OP_EMIT, 1'b1, 1'b1, 1'b0, SET_GAP,   1'b0, 8'h00);
			5'd22: r = uw(OP_EMIT, 1'b1, 1'b0, 1'b0, SET_BYTE,  1'b1, 8'h00);
			default: r = uw(OP_EMIT, 1'b0, 1'b0, 1'b0, SET_BYTE, 1'b1, 8'h00);
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/lcdnib_cfg.sv =====
// configuration register file of the lcd nibble sequencer
`default_nettype none
module lcdnib_cfg
	import lcdnib_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr,
	input  wire logic [2:0]  index,
	input  wire logic [15:0] data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_on <= RST_POWER_ON;
			cfg_q.enable   <= RST_ENABLE;
			cfg_q.gap      <= RST_GAP;
			cfg_q.settle   <= RST_SETTLE;
			cfg_q.clear    <= RST_CLEAR;
		end else if (wr) begin
			case (index)
				CFG_POWER_ON: cfg_q.power_on <= data;
				CFG_ENABLE:   cfg_q.enable   <= data[7:0];
				CFG_GAP:      cfg_q.gap      <= data;
				CFG_SETTLE:   cfg_q.settle   <= data;
				CFG_CLEAR:    cfg_q.clear    <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== design/lcdnib_seq.sv =====
// microprogram sequencer: step counter, control store and exits
`default_nettype none
module lcdnib_seq
	import lcdnib_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire logic [2:0] req_type,
	input  wire logic       cursor_ok,
	output logic            busy,
	output ctl_t            ctl
);

	logic             busy_q;
	logic [UPC_W-1:0] pc_q;
	logic [UPC_W-1:0] entry;
	logic             go;
	uword_t           w;
	logic             done;

	// entry point of each request kind
	always_comb begin
		entry = ENT_BYTE;
		go    = 1'b1;
		case (req_type)
			REQ_CMD, REQ_DATA: entry = ENT_BYTE;
			REQ_INIT:          entry = ENT_INIT;
			REQ_CLEAR:         entry = ENT_CLEAR;
			REQ_CURSOR:        entry = ENT_CURSOR;
			default:           go    = 1'b0;
		endcase
	end

	assign w    = ucode_rom(pc_q);
	assign done = ((w.op == OP_EXIT_BAD) && !cursor_ok) || ((w.op == OP_EMIT) && w.last);

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (load) begin
			busy_q <= go;
			pc_q   <= entry;
		end else if (busy_q) begin
			if (done) begin
				busy_q <= 1'b0;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	assign busy   = busy_q;
	assign ctl.act = busy_q;
	assign ctl.w   = w;

endmodule
`default_nettype wire

// ===== design/lcdnib_dp.sv =====
// datapath: request byte latch and strobe output registers
`default_nettype none
module lcdnib_dp
	import lcdnib_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire logic [2:0]  req_type,
	input  wire logic [7:0]  byte_value,
	input  wire logic [7:0]  cursor_row,
	input  wire logic [7:0]  cursor_column,
	input  wire ctl_t        ctl,
	input  wire cfg_t        cfg,
	output logic             cursor_ok,
	output logic             strobe,
	output logic [3:0]       bus_nibble,
	output logic             register_select,
	output logic [15:0]      wait_before_us,
	output logic [7:0]       pulse_us,
	output logic [16:0]      settle_after_us,
	output logic             last_strobe
);

	logic [7:0]  req_byte_q;
	logic        req_rs_q;
	logic        cursor_ok_q;
	logic        is_cursor;
	logic [7:0]  cur_byte;
	logic [7:0]  src;
	logic [16:0] settle;

	logic        strobe_q;
	logic [3:0]  nib_q;
	logic        rs_q;
	logic [15:0] wait_q;
	logic [7:0]  pulse_q;
	logic [16:0] settle_q;
	logic        last_q;

	// cursor address and position check
	assign is_cursor = (req_type == REQ_CURSOR);
	assign cur_byte  = (cursor_row[0] ? DDRAM_ROW1 : DDRAM_ROW0) + cursor_column;

	// request latch
	always_ff @(posedge clk) begin
		if (load) begin
			req_byte_q  <= is_cursor ? cur_byte : byte_value;
			req_rs_q    <= (req_type == REQ_DATA);
			cursor_ok_q <= (cursor_row[7:1] == 7'd0) && (cursor_column < 8'(COLUMNS));
		end
	end

	assign cursor_ok = cursor_ok_q;

	// strobe fields from the control word
	assign src = ctl.w.use_req ? req_byte_q : ctl.w.cbyte;

	always_comb begin
		case (ctl.w.settle)
			SET_GAP:   settle = {1'b0, cfg.gap};
			SET_BYTE:  settle = {1'b0, cfg.settle};
			SET_CLEAR: settle = {1'b0, cfg.settle} + {1'b0, cfg.clear};
			default:   settle = {1'b0, cfg.gap};
		endcase
	end

	// strobe valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctl.act && (ctl.w.op == OP_EMIT);
		end
	end

	// strobe payload
	always_ff @(posedge clk) begin
		if (ctl.act && (ctl.w.op == OP_EMIT)) begin
			nib_q    <= ctl.w.hi ? src[7:4] : src[3:0];
			rs_q     <= ctl.w.use_req & req_rs_q;
			wait_q   <= ctl.w.wait_pow ? cfg.power_on : 16'd0;
			pulse_q  <= cfg.enable;
			settle_q <= settle;
			last_q   <= ctl.w.last;
		end
	end

	assign strobe          = strobe_q;
	assign bus_nibble      = nib_q;
	assign register_select = rs_q;
	assign wait_before_us  = wait_q;
	assign pulse_us        = pulse_q;
	assign settle_after_us = settle_q;
	assign last_strobe     = last_q;

endmodule
`default_nettype wire

// ===== design/char_lcd_nibble_write_sequencer_top.sv =====
// top level of the character lcd 4-bit write sequencer
//
// A request is taken when start is high and busy is low: req_type selects
// command byte, data byte, power-up init, clear-and-home or set cursor.
// A microprogram then steps once per clock, and each step that sends a
// nibble raises strobe for one cycle, in the cycle after the step, with
// bus_nibble, register_select, wait_before_us, pulse_us, settle_after_us
// and last_strobe. The receiver cannot stall: results must be taken as
// they appear. A request sends 2 strobes for a byte, 14 for init and
// 4 for clear; set cursor spends one extra check step before its 2 strobes,
// and stops at that check with no strobe when row or column is out of range.
// Unknown kinds are taken and produce nothing. The next request can be
// taken in the cycle after the last step, set by the single step counter.
// Registers are written over the cfg channel (cfg_ready always high) and
// take effect on later strobes. Reset clears the step counter and restores
// the register reset values; no strobe is shown during reset.
`default_nettype none
`include "assert_macros.svh"
module char_lcd_nibble_write_sequencer_top
	import lcdnib_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  req_type,
	input  wire logic [7:0]  byte_value,
	input  wire logic [7:0]  cursor_row,
	input  wire logic [7:0]  cursor_column,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic             strobe,
	output logic [3:0]       bus_nibble,
	output logic             register_select,
	output logic [15:0]      wait_before_us,
	output logic [7:0]       pulse_us,
	output logic [16:0]      settle_after_us,
	output logic             last_strobe
);

	logic load;
	logic cursor_ok;
	ctl_t ctl;
	cfg_t cfg;

	// request transaction
	assign load      = start && !busy;
	assign cfg_ready = 1'b1;

	lcdnib_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg_valid && cfg_ready),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	lcdnib_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.req_type  (req_type),
		.cursor_ok (cursor_ok),
		.busy      (busy),
		.ctl       (ctl)
	);

	lcdnib_dp #(
		.COLUMNS (COLUMNS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (load),
		.req_type        (req_type),
		.byte_value      (byte_value),
		.cursor_row      (cursor_row),
		.cursor_column   (cursor_column),
		.ctl             (ctl),
		.cfg             (cfg),
		.cursor_ok       (cursor_ok),
		.strobe          (strobe),
		.bus_nibble      (bus_nibble),
		.register_select (register_select),
		.wait_before_us  (wait_before_us),
		.pulse_us        (pulse_us),
		.settle_after_us (settle_after_us),
		.last_strobe     (last_strobe)
	);

	// a strobe always comes from a step taken while busy
	`LCDNIB_ASSERT_IMP(a_strobe_from_busy, clk, arst_n, strobe, $past(busy))
	// the final strobe of a request frees the sequencer
	`LCDNIB_ASSERT_IMP(a_last_frees, clk, arst_n, strobe && last_strobe, !busy)
	// unknown request kinds never start the program
	`LCDNIB_ASSERT_NXT(a_bad_kind_idle, clk, arst_n,
		start && !busy && (req_type[2] && (req_type[1:0] != 2'b00)), !busy)

endmodule
`default_nettype wire
